@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ hw/rtl/pasmu_pkg.sv @@
`timescale 1ns / 1ps

package pasmu_pkg;

  localparam int MAX_TERMS_DEF    = 16;
  localparam int COEFF_WIDTH_DEF  = 32;

  localparam int COEFF_PORT_WIDTH = 32;
  localparam int DEG_WIDTH        = 5;
  localparam int OUT_DATA_WIDTH   = 40;
  localparam int OUT_USER_WIDTH   = 2;
  localparam int MODE_WIDTH       = 2;

  localparam logic [MODE_WIDTH-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_MUL = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [MODE_WIDTH-1:0] mode;
    logic                  trunc;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic emitting;
  } status_t;

endpackage

@@ hw/rtl/pasmu_opmem.sv @@
`timescale 1ns / 1ps

module pasmu_opmem #(
  parameter int DEPTH = pasmu_pkg::MAX_TERMS_DEF,
  parameter int WIDTH = pasmu_pkg::COEFF_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/pasmu_engine.sv @@
`timescale 1ns / 1ps

module pasmu_engine #(
  parameter int MAX_TERMS   = pasmu_pkg::MAX_TERMS_DEF,
  parameter int COEFF_WIDTH = pasmu_pkg::COEFF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pasmu_pkg::cmd_t                       cmd,
  input  logic [$clog2(MAX_TERMS+1)-1:0]        a_len,
  input  logic [$clog2(MAX_TERMS+1)-1:0]        b_len,
  output logic [$clog2(MAX_TERMS)-1:0]          a_raddr,
  output logic [$clog2(MAX_TERMS)-1:0]          b_raddr,
  input  logic [COEFF_WIDTH-1:0]                a_rdata,
  input  logic [COEFF_WIDTH-1:0]                b_rdata,
  output pasmu_pkg::status_t                    status,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [pasmu_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
  output logic [pasmu_pkg::OUT_USER_WIDTH-1:0]  m_tuser,
  output logic                                  m_tlast
);

  import pasmu_pkg::*;

  localparam int CW   = COEFF_WIDTH;
  localparam int AW   = $clog2(MAX_TERMS);
  localparam int LW   = $clog2(MAX_TERMS + 1);
  localparam int ACC  = 2 * MAX_TERMS - 1;
  localparam int KW   = $clog2(ACC);
  localparam int NW   = $clog2(ACC + 1);
  localparam int XW   = NW + 1;
  localparam int HALF = (CW + 1) / 2;
  localparam int HIW  = CW - HALF;
  localparam int PADW = OUT_DATA_WIDTH - COEFF_PORT_WIDTH - DEG_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]    state;
  logic          mul;
  logic          sub;
  logic          trunc_r;
  logic [LW-1:0] la;
  logic [LW-1:0] lb;
  logic [KW-1:0] n_last;
  logic [KW-1:0] k;
  logic [AW-1:0] i;
  logic [NW-1:0] nz_top;
  logic [KW-1:0] e;
  logic          rd_pend;

  // pipeline: read data, partial products, term, accumulate
  logic          v1, f1, l1, aok1, bok1;
  logic [KW-1:0] k1;
  logic          v2, f2, l2;
  logic [KW-1:0] k2;
  logic [CW-1:0] pp0;
  logic [HIW-1:0] pp1a;
  logic [HIW-1:0] pp1b;
  logic [CW-1:0] sd;
  logic          v3, f3, l3;
  logic [KW-1:0] k3;
  logic [CW-1:0] term;
  logic [CW-1:0] acc;
  logic [CW-1:0] acc_sum;

  logic [CW-1:0] accum [ACC];
  logic [CW-1:0] rdq;

  logic [CW-1:0]     x;
  logic [CW-1:0]     y;
  logic [2*HALF-1:0] p_ll;
  logic [HIW-1:0]    p_lh;
  logic [HIW-1:0]    p_hl;

  logic [XW-1:0] ihi;
  logic [XW-1:0] ilo_cur;
  logic [XW-1:0] ilo_next;
  logic [KW-1:0] diff;
  logic          iss_first;
  logic          iss_last;
  logic          iss_aok;
  logic          iss_bok;
  logic          k_at_end;

  logic          mul_c;
  logic [XW-1:0] n_mul;
  logic [XW-1:0] n_add;
  logic [XW-1:0] n_sel;

  logic          out_free;
  logic          ld_zero;
  logic          ld_item;
  logic          item_last;

  logic                        out_valid;
  logic [COEFF_PORT_WIDTH-1:0] out_coeff;
  logic [DEG_WIDTH-1:0]        out_deg;
  logic                        out_last;
  logic                        out_empty;
  logic                        out_trunc;

  // command decode
  assign mul_c = (cmd.mode != MODE_ADD) && (cmd.mode != MODE_SUB);
  assign n_mul = (a_len == '0 || b_len == '0) ? '0 :
                 XW'(a_len) + XW'(b_len) - XW'(1);
  assign n_add = (a_len > b_len) ? XW'(a_len) : XW'(b_len);
  assign n_sel = mul_c ? n_mul : n_add;

  // issue addressing, convolution walks output degree k and index i
  assign ihi      = (XW'(k) < XW'(la) - XW'(1)) ? XW'(k) : XW'(la) - XW'(1);
  assign ilo_cur  = (XW'(k) + XW'(1) > XW'(lb)) ? XW'(k) + XW'(1) - XW'(lb) : '0;
  assign ilo_next = (XW'(k) + XW'(2) > XW'(lb)) ? XW'(k) + XW'(2) - XW'(lb) : '0;
  assign diff     = k - KW'(i);
  assign k_at_end = (k == n_last);

  assign iss_first = mul ? (XW'(i) == ilo_cur) : 1'b1;
  assign iss_last  = mul ? (XW'(i) == ihi) : 1'b1;
  assign iss_aok   = mul || (XW'(k) < XW'(la));
  assign iss_bok   = mul || (XW'(k) < XW'(lb));

  assign a_raddr = mul ? i : k[AW-1:0];
  assign b_raddr = mul ? diff[AW-1:0] : k[AW-1:0];

  // arithmetic
  assign x    = aok1 ? a_rdata : '0;
  assign y    = bok1 ? b_rdata : '0;
  assign p_ll = (2*HALF)'(x[HALF-1:0]) * (2*HALF)'(y[HALF-1:0]);
  assign p_lh = x[HIW-1:0] * y[CW-1:HALF];
  assign p_hl = x[CW-1:HALF] * y[HIW-1:0];

  assign acc_sum = f3 ? term : acc + term;

  always_ff @(posedge clk) begin
    f1   <= iss_first;
    l1   <= iss_last;
    aok1 <= iss_aok;
    bok1 <= iss_bok;
    k1   <= k;
    f2   <= f1;
    l2   <= l1;
    k2   <= k1;
    pp0  <= p_ll[CW-1:0];
    pp1a <= p_lh;
    pp1b <= p_hl;
    sd   <= sub ? x - y : x + y;
    f3   <= f2;
    l3   <= l2;
    k3   <= k2;
    term <= mul ? pp0 + {pp1a + pp1b, {HALF{1'b0}}} : sd;
    if (v3) begin
      acc <= acc_sum;
    end
  end

  // result store
  always_ff @(posedge clk) begin
    if (v3 && l3) begin
      accum[k3] <= acc_sum;
    end
    rdq <= accum[e];
  end

  // emission
  assign out_free  = !out_valid || m_tready;
  assign ld_zero   = (state == ST_EMIT) && (nz_top == '0) && out_free;
  assign ld_item   = (state == ST_EMIT) && (nz_top != '0) && rd_pend;
  assign item_last = (NW'(e) + NW'(1)) == nz_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      nz_top    <= '0;
      e         <= '0;
      k         <= '0;
      i         <= '0;
    end else begin
      v1 <= (state == ST_ISSUE);
      v2 <= v1;
      v3 <= v2;
      if (v3 && l3 && acc_sum != '0) begin
        nz_top <= NW'(k3) + NW'(1);
      end
      if (ld_zero || ld_item) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            nz_top <= '0;
            e      <= '0;
            k      <= '0;
            i      <= '0;
            if (n_sel == '0) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          if (iss_last && k_at_end) begin
            state <= ST_DRAIN;
          end else if (iss_last) begin
            k <= k + KW'(1);
            i <= AW'(ilo_next);
          end else begin
            i <= i + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state   <= ST_EMIT;
            rd_pend <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (nz_top == '0) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
            if (item_last) begin
              state <= ST_IDLE;
            end else begin
              e <= e + KW'(1);
            end
          end else if (out_free) begin
            rd_pend <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // operation parameters latched per computation
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.start) begin
      mul     <= mul_c;
      sub     <= (cmd.mode == MODE_SUB);
      trunc_r <= cmd.trunc;
      la      <= a_len;
      lb      <= b_len;
      n_last  <= KW'(n_sel - XW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ld_zero) begin
      out_coeff <= '0;
      out_deg   <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
      out_trunc <= trunc_r;
    end else if (ld_item) begin
      out_coeff <= COEFF_PORT_WIDTH'($signed(rdq));
      out_deg   <= DEG_WIDTH'(e);
      out_last  <= item_last;
      out_empty <= 1'b0;
      out_trunc <= trunc_r;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {PADW'(0), out_deg, out_coeff};
  assign m_tuser  = {out_trunc, out_empty};
  assign m_tlast  = out_last;

  assign status.busy     = (state != ST_IDLE);
  assign status.emitting = (state == ST_EMIT);

endmodule

@@ hw/rtl/polynomial_add_sub_multiply_unit.sv @@
`timescale 1ns / 1ps

// Polynomial add / subtract / multiply unit. Operand A and then operand B are streamed in
// as coefficients, lowest degree first, tlast on the highest one; tuser picks the operand.
// The transaction carrying the last coefficient of B starts A+B, A-B or the full product
// A*B, as set by the op_mode register (cfg port). Results leave lowest degree first with
// high zero terms stripped; a zero result is one transaction flagged empty. Coefficients
// past MAX_TERMS are dropped and flag the next result as truncated. Operands sit in two
// single-port-read RAMs and the products are summed per output degree through one
// pipelined multiplier; each result term is then read out through the result RAM read
// port. Loading takes one coefficient per cycle; the input stalls while a computation
// runs, and while its result is emitted only the last coefficient of B waits.
module polynomial_add_sub_multiply_unit #(
  parameter int MAX_TERMS   = pasmu_pkg::MAX_TERMS_DEF,
  parameter int COEFF_WIDTH = pasmu_pkg::COEFF_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [pasmu_pkg::COEFF_PORT_WIDTH-1:0] s_tdata,   // coeff_value
  input  logic                                   s_tuser,   // operand_sel
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [pasmu_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,   // result_coeff, result_degree
  output logic [pasmu_pkg::OUT_USER_WIDTH-1:0]   m_tuser,   // result_empty, truncated
  output logic                                   m_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pasmu_pkg::MODE_WIDTH-1:0]       cfg_data
);

  import pasmu_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int LW = $clog2(MAX_TERMS + 1);

  logic [MODE_WIDTH-1:0]  op_mode;
  logic [LW-1:0]          load_index;
  logic [LW-1:0]          a_length;
  logic                   overflow_seen;

  logic                   accept;
  logic                   full;
  logic [LW-1:0]          idx_inc;
  logic [COEFF_WIDTH-1:0] coeff;
  logic                   wr_a;
  logic                   wr_b;
  logic [AW-1:0]          a_raddr;
  logic [AW-1:0]          b_raddr;
  logic [COEFF_WIDTH-1:0] a_rdata;
  logic [COEFF_WIDTH-1:0] b_rdata;
  cmd_t                   cmd;
  status_t                status;

  assign accept  = s_tvalid && s_tready;
  assign full    = (load_index == LW'(MAX_TERMS));
  assign idx_inc = full ? load_index : load_index + LW'(1);
  assign coeff   = COEFF_WIDTH'($signed(s_tdata));
  assign wr_a    = accept && !full && !s_tuser;
  assign wr_b    = accept && !full && s_tuser;

  assign cmd.start = accept && s_tuser && s_tlast;
  assign cmd.mode  = op_mode;
  assign cmd.trunc = overflow_seen || full;

  // the closing coefficient of B waits while a result is still draining
  assign s_tready  = !status.busy || (status.emitting && !(s_tuser && s_tlast));
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode       <= MODE_MUL;
      load_index    <= '0;
      a_length      <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        op_mode <= cfg_data;
      end
      if (accept) begin
        if (s_tlast) begin
          load_index <= '0;
        end else begin
          load_index <= idx_inc;
        end
        if (s_tlast && !s_tuser) begin
          a_length <= idx_inc;
        end
      end
      if (cmd.start) begin
        overflow_seen <= 1'b0;
      end else if (accept && full) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  pasmu_opmem #(
    .DEPTH (MAX_TERMS),
    .WIDTH (COEFF_WIDTH)
  ) u_a_mem (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (load_index[AW-1:0]),
    .wr_data (coeff),
    .rd_addr (a_raddr),
    .rd_data (a_rdata)
  );

  pasmu_opmem #(
    .DEPTH (MAX_TERMS),
    .WIDTH (COEFF_WIDTH)
  ) u_b_mem (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (load_index[AW-1:0]),
    .wr_data (coeff),
    .rd_addr (b_raddr),
    .rd_data (b_rdata)
  );

  pasmu_engine #(
    .MAX_TERMS   (MAX_TERMS),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .a_len    (a_length),
    .b_len    (idx_inc),
    .a_raddr  (a_raddr),
    .b_raddr  (b_raddr),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ hw/rtl/pasmu_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pasmu_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic                                 s_tuser,
  input logic                                 s_tlast,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [pasmu_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input logic [pasmu_pkg::OUT_USER_WIDTH-1:0] m_tuser,
  input logic                                 m_tlast
);

  // no result right out of reset
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !m_tvalid)

  // an empty result is a single zero term at degree zero
  `ASSERT_IMPLY(a_empty_shape, clk, rst, m_tvalid && m_tuser[0],
    m_tlast && m_tdata[31:0] == 0 && m_tdata[36:32] == 0)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // a computation start blocks the next one in the following cycle
  `ASSERT_NEXT(a_start_blocks, clk, rst, s_tvalid && s_tready && s_tuser && s_tlast,
    !(s_tready && s_tuser && s_tlast))

endmodule

bind polynomial_add_sub_multiply_unit pasmu_checker u_pasmu_checker (.*);
